// ===== src/lap_pkg.sv =====
// ----------------------------------------------------------------------------
// lap_pkg
// Shared constants, types and helpers of the LFO all-pass phaser core.
// ----------------------------------------------------------------------------
package lap_pkg;

  localparam int BUF_DEPTH    = 64;
  localparam int MAX_STAGES   = 8;
  localparam int SINE_ENTRIES = 1024;

  localparam int PTR_W      = $clog2(BUF_DEPTH);
  localparam int CNT_W      = $clog2(MAX_STAGES + 1);
  localparam int SINE_IDX_W = $clog2(SINE_ENTRIES);

  localparam int SMP_W  = 16;
  localparam int OPD_W  = 18;
  localparam int PROD_W = 2 * OPD_W;

  localparam int PADDR_W = 5;

  localparam logic [2:0] REG_PHASE_STEP    = 3'd0;
  localparam logic [2:0] REG_DEPTH_LEVEL   = 3'd1;
  localparam logic [2:0] REG_MIX_LEVEL     = 3'd2;
  localparam logic [2:0] REG_STAGE_COUNT   = 3'd3;
  localparam logic [2:0] REG_EFFECT_ENABLE = 3'd4;
  localparam logic [2:0] REG_OUTPUT_OFFSET = 3'd5;

  localparam logic [15:0] Q15_ONE  = 16'd32768;
  localparam logic [15:0] Q15_HALF = 16'd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X2,
    ST_T,
    ST_U,
    ST_S,
    ST_G,
    ST_GEND,
    ST_STG_MUL,
    ST_STG_ADD,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                    rd_en;
    logic [PTR_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [PTR_W-1:0]        wr_addr;
    logic signed [SMP_W-1:0] wr_data;
  } dly_req_t;

  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > PROD_W'(signed'(32767))) begin
      r = 16'sh7fff;
    end else if (v < -PROD_W'(signed'(32768))) begin
      r = -16'sh8000;
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/lap_mul.sv =====
// ----------------------------------------------------------------------------
// lap_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module lap_mul import lap_pkg::*; (
  input  logic                     clk,
  input  logic signed [OPD_W-1:0]  op_a,
  input  logic signed [OPD_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

// ===== src/lap_dly.sv =====
// ----------------------------------------------------------------------------
// lap_dly
// Circular delay store with per-entry valid bits; unwritten entries read zero.
// ----------------------------------------------------------------------------
module lap_dly import lap_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dly_req_t                req,
  output logic signed [SMP_W-1:0] rd_data
);

  logic signed [SMP_W-1:0] mem [BUF_DEPTH];
  logic [BUF_DEPTH-1:0]    vld_r;
  logic signed [SMP_W-1:0] data_r;
  logic                    hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        hit_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = hit_r ? data_r : '0;

endmodule

// ===== src/lfo_allpass_phaser_core.sv =====
// ----------------------------------------------------------------------------
// lfo_allpass_phaser_core
// Q15 phaser: LFO sine sets the all-pass coefficient, up to MAX_STAGES
// first-order stages share one circular delay store, then dry/wet mix.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | moves
//  ---------+-----------------------------------------+----------------------
//  in       | in_valid, in_ready, in_sample_in        | one dry sample item
//  out      | out_valid, out_ready, out_sample_out    | one processed item
//  cfg      | psel, penable, pwrite, paddr, pwdata,   | register access
//           | prdata, pready                          |
//
//  Enabled item: the single shared multiplier steps through the states in order:
//  sine ST_X2, ST_T, ST_U, ST_S; coefficient ST_G, ST_GEND; ST_STG_MUL and
//  ST_STG_ADD once per active stage; mix ST_MIX1, ST_MIX2, ST_MIX3; then ST_DONE
//  loads the output. Disabled item: straight from idle to ST_DONE. in_ready is
//  high only in idle, so a new item waits until the last one has left ST_DONE.
//  A finished item waits in the output register while out_ready is low.
//  rst_n is synchronous; the delay store reads zero until each entry is written.
// ----------------------------------------------------------------------------
module lfo_allpass_phaser_core import lap_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] in_sample_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] out_sample_out,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [31:0]             phase_step_r;
  logic [14:0]             depth_level_r;
  logic [14:0]             mix_level_r;
  logic [3:0]              stage_count_r;
  logic                    effect_enable_r;
  logic signed [15:0]      output_offset_r;

  state_t                  state_r, state_nxt;
  logic [31:0]             acc_r;
  logic [PTR_W-1:0]        ptr_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [14:0]             x2_r;
  logic signed [16:0]      g_r;
  logic signed [SMP_W-1:0] dry_r;
  logic signed [SMP_W-1:0] wet_r;
  logic signed [SMP_W-1:0] dly_r;
  logic signed [PROD_W-1:0] macc_r;
  logic signed [SMP_W-1:0] res_r;
  logic                    out_valid_r;
  logic signed [SMP_W-1:0] out_sample_r;

  logic signed [OPD_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  dly_req_t                 dly_req;
  logic signed [SMP_W-1:0]  dly_rd;

  logic                     cfg_wr;
  logic [2:0]               reg_idx;
  logic                     in_acc;
  logic                     out_free;

  logic [15:0]              d_eff, m_eff;
  logic [CNT_W-1:0]         n_eff;
  logic [SINE_IDX_W-1:0]    sidx;
  logic [15:0]              q_ang;
  logic [1:0]               quad;
  logic [14:0]              x_val;
  logic [14:0]              t_val;
  logic [15:0]              u_val;
  logic [15:0]              s_mag;
  logic signed [16:0]       s_val;
  logic signed [16:0]       diff;
  logic [PTR_W-1:0]         ptr_inc;
  logic signed [PROD_W-1:0] y_wide;
  logic signed [SMP_W-1:0]  y_sat;
  logic signed [PROD_W-1:0] mix_sum;
  logic signed [PROD_W-1:0] mix_trunc;
  logic signed [SMP_W-1:0]  res_en;
  logic signed [SMP_W-1:0]  res_dis;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= 32'd89478;
      depth_level_r   <= '0;
      mix_level_r     <= '0;
      stage_count_r   <= 4'd6;
      effect_enable_r <= 1'b0;
      output_offset_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PHASE_STEP:    phase_step_r    <= pwdata;
        REG_DEPTH_LEVEL:   depth_level_r   <= pwdata[14:0];
        REG_MIX_LEVEL:     mix_level_r     <= pwdata[14:0];
        REG_STAGE_COUNT:   stage_count_r   <= pwdata[3:0];
        REG_EFFECT_ENABLE: effect_enable_r <= pwdata[0];
        REG_OUTPUT_OFFSET: output_offset_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PHASE_STEP:    prdata = phase_step_r;
      REG_DEPTH_LEVEL:   prdata = {17'd0, depth_level_r};
      REG_MIX_LEVEL:     prdata = {17'd0, mix_level_r};
      REG_STAGE_COUNT:   prdata = {28'd0, stage_count_r};
      REG_EFFECT_ENABLE: prdata = {31'd0, effect_enable_r};
      REG_OUTPUT_OFFSET: prdata = {16'd0, output_offset_r};
      default:           prdata = '0;
    endcase
  end

  // effective settings
  assign d_eff = (depth_level_r == '0) ? Q15_HALF : {1'b0, depth_level_r};
  assign m_eff = (mix_level_r == '0) ? Q15_HALF : {1'b0, mix_level_r};
  assign n_eff = (stage_count_r > 4'(MAX_STAGES)) ? CNT_W'(MAX_STAGES)
                                                  : CNT_W'(stage_count_r);

  // sine angle and intermediate terms
  assign sidx  = acc_r[31 -: SINE_IDX_W];
  assign q_ang = 16'({sidx, {(16 - SINE_IDX_W){1'b0}}});
  assign quad  = q_ang[15:14];
  assign x_val = quad[0] ? (15'd16384 - {1'b0, q_ang[13:0]}) : {1'b0, q_ang[13:0]};
  assign t_val = 15'd21024 - {3'd0, prod[25:14]};
  assign u_val = 16'd51472 - {1'b0, prod[28:14]};
  assign s_mag = prod[29:14];
  assign s_val = quad[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

  assign diff    = 17'(wet_r) - 17'(dly_rd);
  assign ptr_inc = (ptr_r == PTR_W'(BUF_DEPTH - 1)) ? '0 : ptr_r + 1'b1;

  assign y_wide  = PROD_W'(dly_r) + (prod >>> 15);
  assign y_sat   = sat16(y_wide);

  assign mix_sum   = macc_r + prod;
  assign mix_trunc = (mix_sum < 0) ? ((mix_sum + PROD_W'(32767)) >>> 15) : (mix_sum >>> 15);
  assign res_en    = sat16(mix_trunc + PROD_W'(output_offset_r));
  assign res_dis   = sat16(PROD_W'(in_sample_in) + PROD_W'(output_offset_r));

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = effect_enable_r ? ST_X2 : ST_DONE;
        end
      end
      ST_X2:      state_nxt = ST_T;
      ST_T:       state_nxt = ST_U;
      ST_U:       state_nxt = ST_S;
      ST_S:       state_nxt = ST_G;
      ST_G:       state_nxt = ST_GEND;
      ST_GEND:    state_nxt = (n_eff == '0) ? ST_MIX1 : ST_STG_MUL;
      ST_STG_MUL: state_nxt = ST_STG_ADD;
      ST_STG_ADD: state_nxt = (cnt_r + 1'b1 < n_eff) ? ST_STG_MUL : ST_MIX1;
      ST_MIX1:    state_nxt = ST_MIX2;
      ST_MIX2:    state_nxt = ST_MIX3;
      ST_MIX3:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // multiplier operands and delay store requests
  always_comb begin
    op_a            = '0;
    op_b            = '0;
    dly_req.rd_en   = 1'b0;
    dly_req.rd_addr = ptr_r;
    dly_req.wr_en   = 1'b0;
    dly_req.wr_addr = ptr_r;
    dly_req.wr_data = wet_r;
    unique case (state_r)
      ST_X2: begin
        op_a = OPD_W'(x_val);
        op_b = OPD_W'(x_val);
      end
      ST_T: begin
        op_a = OPD_W'(prod[28:14]);
        op_b = OPD_W'(2320);
      end
      ST_U: begin
        op_a = OPD_W'(x2_r);
        op_b = OPD_W'(t_val);
      end
      ST_S: begin
        op_a = OPD_W'(x_val);
        op_b = OPD_W'(u_val);
      end
      ST_G: begin
        op_a = OPD_W'(Q15_ONE - d_eff);
        op_b = OPD_W'(s_val);
      end
      ST_GEND: begin
        dly_req.rd_en = 1'b1;
      end
      ST_STG_MUL: begin
        op_a = OPD_W'(g_r);
        op_b = OPD_W'(diff);
      end
      ST_STG_ADD: begin
        dly_req.wr_en   = 1'b1;
        dly_req.rd_en   = 1'b1;
        dly_req.rd_addr = ptr_inc;
      end
      ST_MIX1: begin
        op_a = OPD_W'(m_eff);
        op_b = OPD_W'(dry_r);
      end
      ST_MIX2: begin
        op_a = OPD_W'(Q15_ONE - m_eff);
        op_b = OPD_W'(wet_r);
      end
      default: ;
    endcase
  end

  lap_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  lap_dly u_dly (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dly_req),
    .rd_data (dly_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && effect_enable_r) begin
        acc_r <= acc_r + phase_step_r;
      end
      if (state_r == ST_GEND) begin
        cnt_r <= '0;
      end else if (state_r == ST_STG_ADD) begin
        cnt_r <= cnt_r + 1'b1;
        ptr_r <= ptr_inc;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dry_r <= in_sample_in;
      wet_r <= in_sample_in;
      res_r <= res_dis;
    end
    if (state_r == ST_T) begin
      x2_r <= prod[28:14];
    end
    if (state_r == ST_GEND) begin
      g_r <= 17'(d_eff) + prod[31:15];
    end
    if (state_r == ST_STG_MUL) begin
      dly_r <= dly_rd;
    end
    if (state_r == ST_STG_ADD) begin
      wet_r <= y_sat;
    end
    if (state_r == ST_MIX2) begin
      macc_r <= prod;
    end
    if (state_r == ST_MIX3) begin
      res_r <= res_en;
    end
    if (state_r == ST_DONE && out_free) begin
      out_sample_r <= res_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lfo_allpass_phaser_core: a directed script of
// register settings and samples, then randomized phases. Every output sample
// is compared with a scripted value or with a bit-exact phaser model in the bench.
// ----------------------------------------------------------------------------
module tb;
  import lap_pkg::*;

  localparam logic [2:0] REG_UNMAPPED = 3'd6;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 128;
  localparam int QUIET_LIMIT = 2000;

  typedef enum logic { ROW_WRITE, ROW_ITEM } row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [2:0]              idx;
    logic [31:0]             val;
    logic signed [SMP_W-1:0] smp;
    bit                      known;
    logic signed [SMP_W-1:0] want;
  } script_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [SMP_W-1:0] in_sample_in;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [SMP_W-1:0] out_sample_out;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  // model of the phaser state and its registers
  logic signed [SMP_W-1:0] taps [BUF_DEPTH];
  int                      tap_ptr;
  logic [31:0]             lfo_acc;
  logic [31:0]             step_r;
  logic [14:0]             depth_r;
  logic [14:0]             mix_r;
  logic [3:0]              stages_r;
  logic                    en_r;
  logic signed [SMP_W-1:0] off_r;

  logic signed [SMP_W-1:0] due_samples [$];
  logic signed [SMP_W-1:0] want;
  script_row_t             script [$];
  int                      mismatches;
  int                      quiet_cycles;
  int                      gap_odds;
  int                      stall_odds;
  int                      stall_left;

  lfo_allpass_phaser_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  function automatic logic signed [SMP_W-1:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[SMP_W-1:0];
  endfunction

  function automatic longint wave_sine(logic [31:0] acc);
    longint idx, q, quad, r, x, x2, t, u, s;
    idx  = (longint'(acc) * SINE_ENTRIES) >> 32;
    q    = ((idx * 65536) / SINE_ENTRIES) & 16'hffff;
    quad = q >> 14;
    r    = q & 16383;
    x    = quad[0] ? 16384 - r : r;
    x2   = (x * x) >> 14;
    t    = 21024 - ((x2 * 2320) >> 14);
    u    = 51472 - ((x2 * t) >> 14);
    s    = (x * u) >> 14;
    return quad[1] ? -s : s;
  endfunction

  function automatic logic signed [SMP_W-1:0] phaser_out(logic signed [SMP_W-1:0] dry);
    longint d, m, n, s, g, wet, dly, mixed;
    int k;
    if (!en_r) return clip16(longint'(dry) + longint'(off_r));
    d = (depth_r != 0) ? longint'(depth_r) : 16384;
    m = (mix_r != 0) ? longint'(mix_r) : 16384;
    n = (stages_r > MAX_STAGES) ? MAX_STAGES : longint'(stages_r);
    lfo_acc = lfo_acc + step_r;
    s = wave_sine(lfo_acc);
    g = d + (((32768 - d) * s) >>> 15);
    wet = dry;
    for (k = 0; k < n; k++) begin
      dly = taps[tap_ptr];
      taps[tap_ptr] = wet[SMP_W-1:0];
      tap_ptr = (tap_ptr + 1) % BUF_DEPTH;
      wet = clip16(dly + ((g * (wet - dly)) >>> 15));
    end
    mixed = m * dry + (32768 - m) * wet;
    mixed = (mixed < 0) ? -((-mixed) >>> 15) : (mixed >>> 15);
    return clip16(mixed + longint'(off_r));
  endfunction

  function automatic script_row_t wr_row(logic [2:0] idx, logic [31:0] val);
    script_row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.val   = val;
    r.smp   = '0;
    r.known = 0;
    r.want  = '0;
    return r;
  endfunction

  function automatic script_row_t item_row(logic signed [SMP_W-1:0] smp, bit known,
                                           logic signed [SMP_W-1:0] want_smp);
    script_row_t r;
    r.kind  = ROW_ITEM;
    r.idx   = '0;
    r.val   = '0;
    r.smp   = smp;
    r.known = known;
    r.want  = want_smp;
    return r;
  endfunction

  function automatic logic [14:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 15'd0;
      1: return 15'd1;
      2: return 15'd32767;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PHASE_STEP:    step_r   = val;
      REG_DEPTH_LEVEL:   depth_r  = val[14:0];
      REG_MIX_LEVEL:     mix_r    = val[14:0];
      REG_STAGE_COUNT:   stages_r = val[3:0];
      REG_EFFECT_ENABLE: en_r     = val[0];
      REG_OUTPUT_OFFSET: off_r    = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(logic signed [SMP_W-1:0] smp, bit known,
                             logic signed [SMP_W-1:0] want_smp);
    logic signed [SMP_W-1:0] predicted;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= smp;
    do @(posedge clk); while (!in_ready);
    predicted = phaser_out(smp);
    due_samples.push_back(known ? want_smp : predicted);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_samples.size() != 0) @(negedge clk);
  endtask

  // receiver: random stall bursts
  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_samples.size() == 0) begin
        $error("sample_out: no item expected, actual %0d", out_sample_out);
        mismatches++;
      end else begin
        want = due_samples.pop_front();
        if (out_sample_out !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, out_sample_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    gap_odds     = 4;
    stall_odds   = 4;
    for (int i = 0; i < BUF_DEPTH; i++) taps[i] = '0;
    tap_ptr  = 0;
    lfo_acc  = '0;
    step_r   = 32'd89478;
    depth_r  = '0;
    mix_r    = '0;
    stages_r = 4'd6;
    en_r     = 1'b0;
    off_r    = '0;

    // disabled after reset, then offset saturation at both ends
    script.push_back(item_row(16'sd0, 1, 16'sd0));
    script.push_back(item_row(16'sh7fff, 1, 16'sh7fff));
    script.push_back(item_row(16'sh8000, 1, 16'sh8000));
    script.push_back(wr_row(REG_OUTPUT_OFFSET, 32'h0000_7fff));
    script.push_back(item_row(16'sh7fff, 1, 16'sh7fff));
    script.push_back(item_row(16'sh8000, 1, -16'sd1));
    script.push_back(wr_row(REG_OUTPUT_OFFSET, 32'h0000_8000));
    script.push_back(item_row(16'sh8000, 1, 16'sh8000));
    script.push_back(item_row(16'sh7fff, 1, -16'sd1));
    // enabled with reset settings: default depth and mix, six stages
    script.push_back(wr_row(REG_OUTPUT_OFFSET, 32'h0));
    script.push_back(wr_row(REG_EFFECT_ENABLE, 32'h1));
    script.push_back(item_row(16'sd0, 0, '0));
    script.push_back(item_row(16'sh7fff, 0, '0));
    script.push_back(item_row(16'sh8000, 0, '0));
    script.push_back(item_row(16'sd12345, 0, '0));
    // no stages: wet equals dry
    script.push_back(wr_row(REG_STAGE_COUNT, 32'h0));
    script.push_back(item_row(16'sd1000, 1, 16'sd1000));
    script.push_back(item_row(16'sh8000, 1, 16'sh8000));
    // stage count above the maximum
    script.push_back(wr_row(REG_STAGE_COUNT, 32'hf));
    script.push_back(item_row(16'sh7fff, 0, '0));
    script.push_back(item_row(16'sh8000, 0, '0));
    script.push_back(item_row(16'sd20000, 0, '0));
    // negative coefficient near -1 drives stage outputs into saturation
    script.push_back(wr_row(REG_DEPTH_LEVEL, 32'h1));
    script.push_back(wr_row(REG_MIX_LEVEL, 32'h1));
    script.push_back(wr_row(REG_PHASE_STEP, 32'hc000_0000));
    script.push_back(item_row(16'sh7fff, 0, '0));
    script.push_back(item_row(16'sh8000, 0, '0));
    script.push_back(item_row(16'sh7fff, 0, '0));
    script.push_back(item_row(16'sh8000, 0, '0));
    script.push_back(wr_row(REG_DEPTH_LEVEL, 32'h7fff));
    script.push_back(wr_row(REG_MIX_LEVEL, 32'h7fff));
    script.push_back(item_row(16'sd5000, 0, '0));
    // unmapped address, then bypass with state held, then resume
    script.push_back(wr_row(REG_UNMAPPED, 32'hffff_ffff));
    script.push_back(wr_row(REG_EFFECT_ENABLE, 32'h0));
    script.push_back(item_row(16'sd777, 1, 16'sd777));
    script.push_back(wr_row(REG_EFFECT_ENABLE, 32'h1));
    script.push_back(item_row(-16'sd1, 0, '0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        drain();
        reg_write(script[i].idx, script[i].val);
      end else begin
        send_sample(script[i].smp, script[i].known, script[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          reg_write(REG_PHASE_STEP, 32'hffff_ffff);
          reg_write(REG_DEPTH_LEVEL, 32'h7fff);
          reg_write(REG_MIX_LEVEL, 32'h7fff);
          reg_write(REG_STAGE_COUNT, MAX_STAGES);
        end
        1: begin
          reg_write(REG_PHASE_STEP, 32'h0);
          reg_write(REG_DEPTH_LEVEL, 32'h1);
          reg_write(REG_MIX_LEVEL, 32'h1);
          reg_write(REG_STAGE_COUNT, 32'h1);
        end
        default: begin
          case ($urandom_range(0, 4))
            0: reg_write(REG_PHASE_STEP, 32'h0);
            1: reg_write(REG_PHASE_STEP, 32'hffff_ffff);
            2: reg_write(REG_PHASE_STEP, $urandom_range(1, 200000));
            default: reg_write(REG_PHASE_STEP, $urandom);
          endcase
          reg_write(REG_DEPTH_LEVEL, 32'(pick_level()));
          reg_write(REG_MIX_LEVEL, 32'(pick_level()));
          reg_write(REG_STAGE_COUNT, $urandom_range(0, 15));
        end
      endcase
      reg_write(REG_EFFECT_ENABLE, 32'((ph == PHASES - 1) || ($urandom_range(0, 4) != 0)));
      case ($urandom_range(0, 5))
        0: reg_write(REG_OUTPUT_OFFSET, 32'h0000_8000);
        1: reg_write(REG_OUTPUT_OFFSET, 32'h0000_7fff);
        2: reg_write(REG_OUTPUT_OFFSET, 32'($urandom_range(0, 512) - 256));
        3: reg_write(REG_OUTPUT_OFFSET, $urandom);
        default: reg_write(REG_OUTPUT_OFFSET, 32'h0);
      endcase
      if ($urandom_range(0, 3) == 0) reg_write(REG_UNMAPPED, $urandom);
      if (ph == PHASES - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
        stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
      end
      for (int k = 0; k < PHASE_LEN; k++) begin
        if (ph == 3 && k == PHASE_LEN / 2) drain();
        send_sample(pick_sample(), 0, '0);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && due_samples.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
